>>> rtl/core/shbi_pkg.sv
// shared types, constants and the mixing function for the string hash bucket index block
package shbi_pkg;

	localparam int unsigned ACC_W    = 32;
	localparam int unsigned HASH_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned DIV_CNT_W = $clog2(HASH_W);

	localparam logic [14:0]       MIX_MULT     = 15'd18000;
	localparam logic [HASH_W-1:0] BUCKET_RESET = 16'd11;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_HOLD
	} back_state_t;

	// acc = (acc & 0xffff) * 18000 + (acc >> 16); stays below 2^32
	function automatic logic [ACC_W-1:0] mix_round(input logic [ACC_W-1:0] acc);
		logic [ACC_W-1:0] prod;
		prod = ACC_W'({16'b0, acc[15:0]}) * ACC_W'(MIX_MULT);
		return prod + ACC_W'(acc[31:16]);
	endfunction

endpackage

>>> rtl/core/shbi_front.sv
// front end: accumulates key bytes and hands the mixed value of each finished key to the queue
module shbi_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [shbi_pkg::BYTE_W-1:0]         key_byte,
	input  logic                                key_last,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [shbi_pkg::ACC_W-1:0]          q_wdata
);

	logic [shbi_pkg::ACC_W-1:0] acc_q;
	logic                       start_q;
	logic [shbi_pkg::ACC_W-1:0] acc_next;
	logic                       accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		if (start_q) begin
			acc_next = shbi_pkg::ACC_W'(key_byte);
		end else begin
			acc_next = shbi_pkg::mix_round(acc_q) + shbi_pkg::ACC_W'(key_byte);
		end
	end

	// final mixing round runs in the back end
	assign q_push  = accept && key_last;
	assign q_wdata = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			start_q <= 1'b1;
		end else if (accept) begin
			acc_q   <= acc_next;
			start_q <= key_last;
		end
	end

endmodule

>>> rtl/core/shbi_fifo.sv
// small queue of finished key accumulators between front and back end
module shbi_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [shbi_pkg::ACC_W-1:0]   wdata,
	input  logic                         pop,
	output logic [shbi_pkg::ACC_W-1:0]   rdata,
	output logic                         full,
	output logic                         empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [shbi_pkg::ACC_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/shbi_back.sv
// back end: final mixing round, bit-serial modulo by the bucket count, output register
module shbi_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  logic [shbi_pkg::ACC_W-1:0]    q_rdata,
	output logic                          q_pop,
	input  logic [shbi_pkg::HASH_W-1:0]   bucket_count,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [shbi_pkg::HASH_W-1:0]   hash_value,
	output logic [shbi_pkg::HASH_W-1:0]   bucket_index
);

	shbi_pkg::back_state_t state_q, state_d;

	logic [shbi_pkg::HASH_W-1:0]    hash_q;
	logic [shbi_pkg::HASH_W-1:0]    dvd_q;
	logic [shbi_pkg::HASH_W-1:0]    rem_q;
	logic [shbi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [shbi_pkg::ACC_W-1:0]     mixed;
	logic [shbi_pkg::HASH_W:0]      trial;
	logic [shbi_pkg::HASH_W-1:0]    rem_next;
	logic                           out_free;
	logic                           load_out;
	logic                           out_valid_q;
	logic [shbi_pkg::HASH_W-1:0]    out_hash_q;
	logic [shbi_pkg::HASH_W-1:0]    out_bucket_q;

	assign mixed    = shbi_pkg::mix_round(q_rdata);
	assign trial    = {rem_q, dvd_q[shbi_pkg::HASH_W-1]};
	assign rem_next = (trial >= {1'b0, bucket_count})
		? shbi_pkg::HASH_W'(trial - {1'b0, bucket_count})
		: shbi_pkg::HASH_W'(trial);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			shbi_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = shbi_pkg::B_DIV;
				end
			end
			shbi_pkg::B_DIV: begin
				if (cnt_q == '1) begin
					state_d = shbi_pkg::B_HOLD;
				end
			end
			shbi_pkg::B_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = shbi_pkg::B_IDLE;
				end
			end
			default: state_d = shbi_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shbi_pkg::B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == shbi_pkg::B_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == shbi_pkg::B_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// restoring division, one quotient bit per cycle, msb first
	always_ff @(posedge clk) begin
		if (q_pop) begin
			hash_q <= mixed[shbi_pkg::HASH_W-1:0];
			dvd_q  <= mixed[shbi_pkg::HASH_W-1:0];
			rem_q  <= '0;
		end else if (state_q == shbi_pkg::B_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[shbi_pkg::HASH_W-2:0], 1'b0};
		end
		if (load_out) begin
			out_hash_q   <= hash_q;
			out_bucket_q <= (bucket_count == '0) ? '0 : rem_q;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign hash_value   = out_hash_q;
	assign bucket_index = out_bucket_q;

endmodule

>>> rtl/core/string_hash_bucket_index.sv
// Path: the last key byte is written to the queue, popped with the final mix, run through
// 16 division steps, held until the output is free, then loaded into the output register.
// Throughput: one key byte per cycle into the front end while the queue is not full; the back end
// finishes one key in its bit-serial divider before it pops the next. The queue lets the next key stream in meanwhile.
// Reset: arst_n clears the accumulator, marks the next byte as a key start, empties the queue,
// idles the divider and sets bucket_count to 11.
module string_hash_bucket_index #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_byte
	input  logic        s_tlast,   // key_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] hash_value, [31:16] bucket_index
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // bucket_count
);

	logic [shbi_pkg::HASH_W-1:0] bucket_count_q;
	logic                        q_push;
	logic                        q_pop;
	logic                        q_full;
	logic                        q_empty;
	logic [shbi_pkg::ACC_W-1:0]  q_wdata;
	logic [shbi_pkg::ACC_W-1:0]  q_rdata;
	logic [shbi_pkg::HASH_W-1:0] hash_value;
	logic [shbi_pkg::HASH_W-1:0] bucket_index;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= shbi_pkg::BUCKET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bucket_count_q <= cfg_data;
		end
	end

	shbi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.key_byte (s_tdata),
		.key_last (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	shbi_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	shbi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.bucket_count (bucket_count_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.hash_value   (hash_value),
		.bucket_index (bucket_index)
	);

	assign m_tdata = {bucket_index, hash_value};

endmodule
